// ===== rtl/cau_pkg.sv =====
`timescale 1ns / 1ps
package cau_pkg;

   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_DIV = 3'd3;
   localparam logic [2:0] OP_MOD = 3'd4;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_DIVZERO = 2'd1;
   localparam logic [1:0] ST_SAT     = 2'd2;

   // quotient bits kept by the divider, also the number of root digits
   localparam int QBITS       = 34;
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic addsub;
      logic sub;
      logic mul;
      logic div;
      logic modu;
   } class_type;

   typedef struct packed {
      class_type          cls;
      logic signed [31:0] ar;
      logic signed [31:0] ai;
      logic signed [31:0] br;
      logic signed [31:0] bi;
   } item_type;

   typedef struct packed {
      logic [63:0]      rem;
      logic [QBITS-1:0] quo;
      logic [QBITS-1:0] low;
   } div_type;

   typedef struct packed {
      logic [35:0]        rem;
      logic [QBITS-1:0]   root;
      logic [2*QBITS-1:0] src;
   } sqrt_type;

   typedef struct packed {
      logic [31:0] val;
      logic        sat;
   } fin_type;

   // clamp a sign and magnitude pair to 32-bit two's complement
   function automatic fin_type finish(input logic neg, input logic [63:0] mag);
      fin_type f;
      f.sat = 1'b0;
      f.val = mag[31:0];
      if (!neg && mag > 64'h7FFF_FFFF) begin
         f.val = 32'h7FFF_FFFF;
         f.sat = 1'b1;
      end else if (neg && mag > 64'h8000_0000) begin
         f.val = 32'h8000_0000;
         f.sat = 1'b1;
      end else if (neg) begin
         f.val = 32'd0 - mag[31:0];
      end
      return f;
   endfunction

endpackage

// ===== rtl/cau_front.sv =====
`timescale 1ns / 1ps
module cau_front import cau_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [2:0]  req_type,
   input  logic [31:0] req_first_real,
   input  logic [31:0] req_first_imag,
   input  logic [31:0] req_second_real,
   input  logic [31:0] req_second_imag,
   input  logic        q_full,
   output logic        fr_vld,
   output item_type    fr_item
);

   logic      vld_ff, vld_in;
   item_type  item_ff, item_in;
   class_type cls;
   logic      take, move;

   always_comb begin
      cls = '0;
      case (req_type)
         OP_ADD: cls.addsub = 1'b1;
         OP_SUB: begin
            cls.addsub = 1'b1;
            cls.sub    = 1'b1;
         end
         OP_MUL: cls.mul  = 1'b1;
         OP_DIV: cls.div  = 1'b1;
         OP_MOD: cls.modu = 1'b1;
         default: cls = '0;
      endcase
   end

   assign full = vld_ff && q_full;
   assign take = push && !full;
   assign move = vld_ff && !q_full;

   always_comb begin
      item_in.cls = cls;
      item_in.ar  = req_first_real;
      item_in.ai  = req_first_imag;
      item_in.br  = req_second_real;
      item_in.bi  = req_second_imag;
      vld_in = vld_ff;
      if (take) begin
         vld_in = 1'b1;
      end else if (move) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign fr_vld  = vld_ff;
   assign fr_item = item_ff;

endmodule

// ===== rtl/cau_queue.sv =====
`timescale 1ns / 1ps
module cau_queue import cau_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     q_push,
   input  item_type q_din,
   output logic     q_full,
   input  logic     q_pop,
   output item_type q_dout,
   output logic     q_empty
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   item_type        mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign q_full  = (count_ff == CW'(QUEUE_DEPTH));
   assign q_empty = (count_ff == '0);
   assign q_dout  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (q_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (q_push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (q_pop && !q_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         mem_ff[wr_ptr_ff] <= q_din;
      end
   end

endmodule

// ===== rtl/cau_div_step.sv =====
`timescale 1ns / 1ps
module cau_div_step import cau_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] divisor,
   input  div_type     din,
   output div_type     dout
);

   div_type     nxt_ff, nxt_in;
   logic [64:0] trial;
   logic [64:0] diff;
   logic        ge;

   // one restoring step: bring down the next dividend bit
   always_comb begin
      trial = {din.rem, din.low[QBITS-1]};
      diff  = trial - {1'b0, divisor};
      ge    = (trial >= {1'b0, divisor});
      nxt_in.rem = ge ? diff[63:0] : trial[63:0];
      nxt_in.quo = {din.quo[QBITS-2:0], ge};
      nxt_in.low = {din.low[QBITS-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nxt_ff <= nxt_in;
      end
   end

   assign dout = nxt_ff;

endmodule

// ===== rtl/cau_sqrt_step.sv =====
`timescale 1ns / 1ps
module cau_sqrt_step import cau_pkg::*; (
   input  logic     clock,
   input  logic     en,
   input  sqrt_type din,
   output sqrt_type dout
);

   sqrt_type    nxt_ff, nxt_in;
   logic [37:0] cur;
   logic [37:0] trial;
   logic [37:0] diff;
   logic        ge;

   // one root digit per step, two radicand bits brought down
   always_comb begin
      cur   = {din.rem, din.src[2*QBITS-1 -: 2]};
      trial = {2'b00, din.root, 2'b01};
      diff  = cur - trial;
      ge    = (cur >= trial);
      nxt_in.rem  = ge ? diff[35:0] : cur[35:0];
      nxt_in.root = {din.root[QBITS-2:0], ge};
      nxt_in.src  = {din.src[2*QBITS-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nxt_ff <= nxt_in;
      end
   end

   assign dout = nxt_ff;

endmodule

// ===== rtl/cau_back.sv =====
`timescale 1ns / 1ps
module cau_back import cau_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_empty,
   input  item_type    q_item,
   output logic        q_pop,
   input  logic        pop,
   output logic        empty,
   output logic [31:0] rsp_result_real,
   output logic [31:0] rsp_result_imag,
   output logic [1:0]  rsp_status
);

   localparam int          NW   = 65 + FRAC_BITS;
   localparam logic [63:0] HALF = (64'd1 << FRAC_BITS) >> 1;

   typedef struct packed {
      class_type   cls;
      logic [31:0] e_re;
      logic [31:0] e_im;
      logic        e_sat;
      logic        neg_r;
      logic        neg_i;
      logic        ovf_r;
      logic        ovf_i;
      logic        dz;
   } side_type;

   logic adv;

   // stage 1: products and sum
   logic               v1_ff;
   side_type           sd1_ff, sd1_in;
   logic signed [63:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, p_sx_ff, p_sy_ff;
   logic signed [63:0] p_rr_in, p_ii_in, p_ri_in, p_ir_in, p_sx_in, p_sy_in;
   logic signed [33:0] s_r, s_i;
   logic [33:0]        m_r, m_i;
   logic signed [31:0] sx, sy;
   fin_type            f_ar, f_ai;

   // stage 2: combined dot products
   logic               v2_ff;
   side_type           sd2_ff;
   logic signed [64:0] xr2_ff, xi2_ff, xr2_in, xi2_in;
   logic [63:0]        sq2_ff, sq2_in;

   // stage 3: magnitudes
   logic               v3_ff;
   side_type           sd3_ff, sd3_in;
   logic [63:0]        mr3_ff, mi3_ff, sq3_ff;
   logic [64:0]        ar65, ai65;

   // stage 4 and the iteration chain
   logic               vc_ff [0:QBITS];
   side_type           sd_ff [0:QBITS];
   logic [63:0]        d_ff  [0:QBITS-1];
   side_type           sd0_in;
   div_type            dr0_ff, di0_ff, dr0_in, di0_in;
   sqrt_type           sq0_ff, sq0_in;
   div_type            dr [0:QBITS];
   div_type            di [0:QBITS];
   sqrt_type           sq [0:QBITS];
   logic [NW-1:0]      n_r, n_i;
   logic [63:0]        top_r, top_i, rnd_r, rnd_i;
   fin_type            f_mr, f_mi;

   // output
   logic               out_vld_ff;
   logic [31:0]        re_ff, im_ff, re_in, im_in;
   logic [1:0]         st_ff, st_in;
   side_type           sf;
   logic [QBITS:0]     qr_sum, qi_sum;
   logic [63:0]        dmag_r, dmag_i, root_rnd;
   fin_type            f_dr, f_di, f_sq;
   logic               sat;

   assign adv   = !out_vld_ff || pop;
   assign q_pop = adv && !q_empty;

   // ---------------- stage 1
   always_comb begin
      s_r = 34'($signed(q_item.ar)) +
            (q_item.cls.sub ? -34'($signed(q_item.br)) : 34'($signed(q_item.br)));
      s_i = 34'($signed(q_item.ai)) +
            (q_item.cls.sub ? -34'($signed(q_item.bi)) : 34'($signed(q_item.bi)));
      m_r = s_r[33] ? 34'(-s_r) : 34'(s_r);
      m_i = s_i[33] ? 34'(-s_i) : 34'(s_i);
      f_ar = finish(s_r[33], {30'd0, m_r});
      f_ai = finish(s_i[33], {30'd0, m_i});
      sd1_in       = '0;
      sd1_in.cls   = q_item.cls;
      sd1_in.e_re  = f_ar.val;
      sd1_in.e_im  = f_ai.val;
      sd1_in.e_sat = f_ar.sat || f_ai.sat;
      if (!q_item.cls.addsub) begin
         sd1_in.e_re  = '0;
         sd1_in.e_im  = '0;
         sd1_in.e_sat = 1'b0;
      end
      // the two squarers serve |b|^2 for a quotient, |a|^2 otherwise
      sx = q_item.cls.div ? $signed(q_item.br) : $signed(q_item.ar);
      sy = q_item.cls.div ? $signed(q_item.bi) : $signed(q_item.ai);
      p_rr_in = $signed(q_item.ar) * $signed(q_item.br);
      p_ii_in = $signed(q_item.ai) * $signed(q_item.bi);
      p_ri_in = $signed(q_item.ar) * $signed(q_item.bi);
      p_ir_in = $signed(q_item.ai) * $signed(q_item.br);
      p_sx_in = sx * sx;
      p_sy_in = sy * sy;
   end

   // ---------------- stage 2
   always_comb begin
      if (sd1_ff.cls.mul) begin
         xr2_in = 65'(p_rr_ff) - 65'(p_ii_ff);
         xi2_in = 65'(p_ir_ff) + 65'(p_ri_ff);
      end else begin
         xr2_in = 65'(p_rr_ff) + 65'(p_ii_ff);
         xi2_in = 65'(p_ir_ff) - 65'(p_ri_ff);
      end
      sq2_in = $unsigned(p_sx_ff) + $unsigned(p_sy_ff);
   end

   // ---------------- stage 3
   always_comb begin
      ar65 = xr2_ff[64] ? 65'(-xr2_ff) : 65'(xr2_ff);
      ai65 = xi2_ff[64] ? 65'(-xi2_ff) : 65'(xi2_ff);
      sd3_in       = sd2_ff;
      sd3_in.neg_r = xr2_ff[64];
      sd3_in.neg_i = xi2_ff[64];
      sd3_in.dz    = (sq2_ff == '0);
   end

   // ---------------- stage 4: product rounding, divider and root setup
   always_comb begin
      rnd_r = (mr3_ff + HALF) >> FRAC_BITS;
      rnd_i = (mi3_ff + HALF) >> FRAC_BITS;
      f_mr  = finish(sd3_ff.neg_r, rnd_r);
      f_mi  = finish(sd3_ff.neg_i, rnd_i);
      n_r   = NW'(mr3_ff) << (FRAC_BITS + 1);
      n_i   = NW'(mi3_ff) << (FRAC_BITS + 1);
      top_r = 64'(n_r[NW-1:QBITS]);
      top_i = 64'(n_i[NW-1:QBITS]);
      sd0_in       = sd3_ff;
      // quotient wider than QBITS bits is certain to saturate
      sd0_in.ovf_r = (top_r >= sq3_ff);
      sd0_in.ovf_i = (top_i >= sq3_ff);
      if (sd3_ff.cls.mul) begin
         sd0_in.e_re  = f_mr.val;
         sd0_in.e_im  = f_mi.val;
         sd0_in.e_sat = f_mr.sat || f_mi.sat;
      end
      dr0_in.rem = sd0_in.ovf_r ? '0 : top_r;
      dr0_in.quo = '0;
      dr0_in.low = n_r[QBITS-1:0];
      di0_in.rem = sd0_in.ovf_i ? '0 : top_i;
      di0_in.quo = '0;
      di0_in.low = n_i[QBITS-1:0];
      sq0_in.rem  = '0;
      sq0_in.root = '0;
      sq0_in.src  = (2*QBITS)'(sq3_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vc_ff[0] <= 1'b0;
      end else if (adv) begin
         v1_ff <= !q_empty;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         vc_ff[0] <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sd1_ff  <= sd1_in;
         p_rr_ff <= p_rr_in;
         p_ii_ff <= p_ii_in;
         p_ri_ff <= p_ri_in;
         p_ir_ff <= p_ir_in;
         p_sx_ff <= p_sx_in;
         p_sy_ff <= p_sy_in;
         sd2_ff  <= sd1_ff;
         xr2_ff  <= xr2_in;
         xi2_ff  <= xi2_in;
         sq2_ff  <= sq2_in;
         sd3_ff  <= sd3_in;
         mr3_ff  <= ar65[63:0];
         mi3_ff  <= ai65[63:0];
         sq3_ff  <= sq2_ff;
         sd_ff[0] <= sd0_in;
         d_ff[0]  <= sq3_ff;
         dr0_ff   <= dr0_in;
         di0_ff   <= di0_in;
         sq0_ff   <= sq0_in;
      end
   end

   assign dr[0] = dr0_ff;
   assign di[0] = di0_ff;
   assign sq[0] = sq0_ff;

   for (genvar k = 0; k < QBITS; k++) begin : g_step
      cau_div_step u_div_r (
         .clock   (clock),
         .en      (adv),
         .divisor (d_ff[k]),
         .din     (dr[k]),
         .dout    (dr[k+1])
      );
      cau_div_step u_div_i (
         .clock   (clock),
         .en      (adv),
         .divisor (d_ff[k]),
         .din     (di[k]),
         .dout    (di[k+1])
      );
      cau_sqrt_step u_sqrt (
         .clock (clock),
         .en    (adv),
         .din   (sq[k]),
         .dout  (sq[k+1])
      );

      always_ff @(posedge clock) begin
         if (reset) begin
            vc_ff[k+1] <= 1'b0;
         end else if (adv) begin
            vc_ff[k+1] <= vc_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sd_ff[k+1] <= sd_ff[k];
         end
      end

      if (k < QBITS - 1) begin : g_d
         always_ff @(posedge clock) begin
            if (adv) begin
               d_ff[k+1] <= d_ff[k];
            end
         end
      end
   end

   // ---------------- final rounding and selection
   always_comb begin
      sf     = sd_ff[QBITS];
      qr_sum = {1'b0, dr[QBITS].quo} + 1'b1;
      qi_sum = {1'b0, di[QBITS].quo} + 1'b1;
      dmag_r = sf.ovf_r ? '1 : 64'(qr_sum[QBITS:1]);
      dmag_i = sf.ovf_i ? '1 : 64'(qi_sum[QBITS:1]);
      f_dr   = finish(sf.neg_r, dmag_r);
      f_di   = finish(sf.neg_i, dmag_i);
      root_rnd = 64'(sq[QBITS].root) +
                 64'(sq[QBITS].rem > 36'(sq[QBITS].root));
      f_sq   = finish(1'b0, root_rnd);
      re_in  = '0;
      im_in  = '0;
      sat    = 1'b0;
      st_in  = ST_OK;
      if (sf.cls.addsub || sf.cls.mul) begin
         re_in = sf.e_re;
         im_in = sf.e_im;
         sat   = sf.e_sat;
      end else if (sf.cls.div) begin
         if (!sf.dz) begin
            re_in = f_dr.val;
            im_in = f_di.val;
            sat   = f_dr.sat || f_di.sat;
         end
      end else if (sf.cls.modu) begin
         re_in = f_sq.val;
         sat   = f_sq.sat;
      end
      if (sf.cls.div && sf.dz) begin
         st_in = ST_DIVZERO;
      end else if (sat) begin
         st_in = ST_SAT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= vc_ff[QBITS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         re_ff <= re_in;
         im_ff <= im_in;
         st_ff <= st_in;
      end
   end

   assign empty           = !out_vld_ff;
   assign rsp_result_real = re_ff;
   assign rsp_result_imag = im_ff;
   assign rsp_status      = st_ff;

endmodule

// ===== rtl/complex_arithmetic_unit_top.sv =====
`timescale 1ns / 1ps
// complex arithmetic unit, signed fixed point with FRAC_BITS fraction bits
// request side is a queue write port: an item enters when push is high and
// full is low; it carries the operation and the two complex operands
// result side is a queue read port: while empty is low the oldest result
// sits on the rsp_ ports and leaves when pop is high
// the front register classifies the operation and hands the item to a
// two-entry queue; the back pipeline then takes one item per cycle while
// no shown result waits for pop; from push to the result showing, an item
// passes the front register, the queue, the stages of products, sums,
// magnitudes and setup, the pipelined divider and square root (one
// quotient bit or one root digit per stage), and the output register
// throughput is one item per cycle for every operation while pop keeps
// the output moving; when pop stays low with a result shown, the back
// pipeline holds; the queue and the front register still take up to three
// more items before full rises
// reset empties the queue and the pipeline; nothing is shown until a new
// item has gone through
module complex_arithmetic_unit_top import cau_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [2:0]  req_type,
   input  logic [31:0] req_first_real,
   input  logic [31:0] req_first_imag,
   input  logic [31:0] req_second_real,
   input  logic [31:0] req_second_imag,
   output logic        empty,
   input  logic        pop,
   output logic [31:0] rsp_result_real,
   output logic [31:0] rsp_result_imag,
   output logic [1:0]  rsp_status
);

   logic     fr_vld;
   item_type fr_item;
   logic     q_full, q_push, q_pop, q_empty;
   item_type q_dout;

   cau_front u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_type        (req_type),
      .req_first_real  (req_first_real),
      .req_first_imag  (req_first_imag),
      .req_second_real (req_second_real),
      .req_second_imag (req_second_imag),
      .q_full          (q_full),
      .fr_vld          (fr_vld),
      .fr_item         (fr_item)
   );

   assign q_push = fr_vld && !q_full;

   cau_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_din   (fr_item),
      .q_full  (q_full),
      .q_pop   (q_pop),
      .q_dout  (q_dout),
      .q_empty (q_empty)
   );

   cau_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_item          (q_dout),
      .q_pop           (q_pop),
      .pop             (pop),
      .empty           (empty),
      .rsp_result_real (rsp_result_real),
      .rsp_result_imag (rsp_result_imag),
      .rsp_status      (rsp_status)
   );

endmodule

// ===== rtl/cau_checker.sv =====
`timescale 1ns / 1ps
module cau_checker import cau_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        full,
   input logic        empty,
   input logic        pop,
   input logic [31:0] rsp_result_real,
   input logic [31:0] rsp_result_imag,
   input logic [1:0]  rsp_status
);

   a_reset_empty: assert property (@(posedge clock) reset |=> empty && !full)
      else $error("queue not empty after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_result_real)
                         && $stable(rsp_result_imag) && $stable(rsp_status))
      else $error("stalled result changed");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      !empty |-> rsp_status != 2'd3)
      else $error("status code out of range");

   a_divzero_zero: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_status == ST_DIVZERO |->
         rsp_result_real == 32'd0 && rsp_result_imag == 32'd0)
      else $error("divide by zero with nonzero result");

   a_sat_clamped: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_status == ST_SAT |->
         rsp_result_real == 32'h7FFF_FFFF || rsp_result_real == 32'h8000_0000 ||
         rsp_result_imag == 32'h7FFF_FFFF || rsp_result_imag == 32'h8000_0000)
      else $error("saturation flagged without a clamped part");

endmodule

bind complex_arithmetic_unit_top cau_checker u_cau_checker (.*);
